// ===== sv/osat_pkg.sv =====
package osat_pkg;

   // Component and derived widths of the fixed point box data
   localparam int COMP_BITS = 16;
   localparam int VEC_BITS  = 3 * COMP_BITS;
   localparam int DIFF_BITS = COMP_BITS + 1;
   localparam int XPROD_BITS = 2 * COMP_BITS;
   localparam int AXIS_BITS = 2 * COMP_BITS + 1;
   localparam int PROD_BITS = AXIS_BITS + DIFF_BITS;
   localparam int DOT_BITS  = PROD_BITS + 2;
   localparam int SUM_BITS  = DOT_BITS + 3;
   localparam int NUM_AXES  = 15;

   // Request kinds carried in req_tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TEST = 1'b1;

   typedef logic signed [COMP_BITS-1:0] comp_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [XPROD_BITS-1:0] xprod_type;
   typedef logic signed [AXIS_BITS-1:0] axis_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [DOT_BITS-1:0] dot_type;
   typedef logic [SUM_BITS-1:0] sum_type;

   // Component k of a packed vector
   function automatic comp_type get_comp(input logic [VEC_BITS-1:0] v, input int k);
      get_comp = comp_type'(v[k*COMP_BITS +: COMP_BITS]);
   endfunction

endpackage

// ===== sv/osat_axis.sv =====
// Separation test along one axis: products, absolute dot sums, then
// compare of twice the offset projection against the sum of row projections.
module osat_axis
   import osat_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  axis_type axis [3],
   input  comp_type rows [6][3],
   input  diff_type d    [3],
   output logic     sep
);

   prod_type prod_ff [7][3];
   prod_type prod_in [7][3];
   sum_type  adot_ff [7];
   sum_type  adot_in [7];
   logic     sep_ff;
   logic     sep_in;

   // Stage A: one multiplier per row and component; dot 6 is the center offset
   always_comb begin
      for (int r = 0; r < 7; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (r < 6) begin
               prod_in[r][k] = prod_type'(diff_type'(rows[r][k])) * prod_type'(axis[k]);
            end else begin
               prod_in[r][k] = prod_type'(d[k]) * prod_type'(axis[k]);
            end
         end
      end
   end

   // Stage B: sum of three products and magnitude
   always_comb begin
      dot_type s;
      for (int r = 0; r < 7; r++) begin
         s = dot_type'(prod_ff[r][0]) + dot_type'(prod_ff[r][1]) + dot_type'(prod_ff[r][2]);
         adot_in[r] = s[DOT_BITS-1] ? sum_type'(-s) : sum_type'(s);
      end
   end

   // Stage C: 2|d.A| > sum of |row.A| means separated
   always_comb begin
      sum_type total;
      total = '0;
      for (int r = 0; r < 6; r++) begin
         total = total + adot_ff[r];
      end
      sep_in = {adot_ff[6][SUM_BITS-2:0], 1'b0} > total;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         adot_ff <= adot_in;
         sep_ff  <= sep_in;
      end
   end

   assign sep = sep_ff;

endmodule

// ===== sv/obb_separating_axis_test.sv =====
// Oriented box overlap test over the 15 separating axes. An item with
// req_tuser = 0 loads the reference box (three scaled axis rows and the
// center) and gives no result; an item with req_tuser = 1 tests its box
// against the stored reference and returns one result, hit = 1 when no
// axis separates the boxes (touching counts as a hit). Fully pipelined:
// one item per cycle while not stalled, through seven register stages
// (operand capture, cross products, cross axes, projections, dot sums,
// axis compare, hit reduce).
// A load takes effect for the very next item.
// A stall on rsp_tready holds the whole pipeline.
module obb_separating_axis_test
   import osat_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [191:0]  req_tdata,  // row_0[47:0], row_1[95:48], row_2[143:96], origin[191:144]
   input  logic          req_tuser,  // func
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata   // hit[0], zero fill above
);

   logic                en;
   logic                accept;
   logic [VEC_BITS-1:0] ref_ff [4];

   // Stage 1: operands
   logic     v1_ff;
   comp_type rows1_ff [6][3];
   diff_type d1_ff    [3];
   // Stage 2: cross products
   logic      v2_ff;
   comp_type  rows2_ff [6][3];
   diff_type  d2_ff    [3];
   xprod_type xp_ff    [9][3][2];
   xprod_type xp_in    [9][3][2];
   // Stage 3: axes
   logic     v3_ff;
   comp_type rows3_ff [6][3];
   diff_type d3_ff    [3];
   axis_type ax_ff    [NUM_AXES][3];
   axis_type ax_in    [NUM_AXES][3];
   // Axis units, stages 4 to 6
   logic [2:0]          vq_ff;
   logic [NUM_AXES-1:0] sep;
   // Stage 7: result
   logic rsp_tvalid_ff;
   logic hit_ff;

   assign en         = rsp_tready || !rsp_tvalid_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // Reference box store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) ref_ff[i] <= '0;
      end else if (accept && req_tuser == FUNC_LOAD) begin
         for (int i = 0; i < 4; i++) ref_ff[i] <= req_tdata[i*VEC_BITS +: VEC_BITS];
      end
   end

   // Cross products of reference row i and test row j
   always_comb begin
      int a1, a2;
      for (int n = 0; n < 9; n++) begin
         for (int k = 0; k < 3; k++) begin
            a1 = (k + 1) % 3;
            a2 = (k + 2) % 3;
            xp_in[n][k][0] = xprod_type'(rows1_ff[n/3][a1]) * xprod_type'(rows1_ff[3+n%3][a2]);
            xp_in[n][k][1] = xprod_type'(rows1_ff[n/3][a2]) * xprod_type'(rows1_ff[3+n%3][a1]);
         end
      end
   end

   // Face axes are the rows; cross axes are product differences
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 6; r++) begin
            ax_in[r][k] = axis_type'(rows2_ff[r][k]);
         end
         for (int n = 0; n < 9; n++) begin
            ax_in[6+n][k] = axis_type'(xp_ff[n][k][0]) - axis_type'(xp_ff[n][k][1]);
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
               rows1_ff[r][k]   <= get_comp(ref_ff[r], k);
               rows1_ff[3+r][k] <= get_comp(req_tdata[r*VEC_BITS +: VEC_BITS], k);
            end
            d1_ff[k] <= diff_type'(get_comp(req_tdata[3*VEC_BITS +: VEC_BITS], k))
                      - diff_type'(get_comp(ref_ff[3], k));
         end
         rows2_ff <= rows1_ff;
         d2_ff    <= d1_ff;
         xp_ff    <= xp_in;
         rows3_ff <= rows2_ff;
         d3_ff    <= d2_ff;
         ax_ff    <= ax_in;
         hit_ff   <= ~|sep;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         vq_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         v1_ff         <= req_tvalid && req_tuser == FUNC_TEST;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         vq_ff         <= {vq_ff[1:0], v3_ff};
         rsp_tvalid_ff <= vq_ff[2];
      end
   end

   // One test unit per axis
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      osat_axis u_axis (
         .clock (clock),
         .en    (en),
         .axis  (ax_ff[g]),
         .rows  (rows3_ff),
         .d     (d3_ff),
         .sep   (sep[g])
      );
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, hit_ff};

endmodule
